FILE: rtl/flba_pkg.sv
// flba_pkg: shared constants, status codes and controller/datapath handshake
// structs for the free-list block allocator.
// No dependencies.
package flba_pkg;

    // Field widths fixed by the interface
    localparam int CFG_W    = 9;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;

    // Pool size default and block count after reset
    localparam int NUM_BLOCKS_DEF = 256;
    localparam int COUNT_RESET    = 256;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic cfg_load;    // take new block count, restart relink sweep
        logic sweep_step;  // write one link entry of the relink sweep
        logic accept;      // item taken this cycle
        logic finish;      // complete a pending pop
    } flba_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic head_null;   // free list is empty
        logic sweep_last;  // sweep pointer at final entry
    } flba_stat_t;

endpackage

FILE: rtl/free_list_block_allocator.sv
// Free-list block allocator. After reset, and after every block_count write,
// a relink sweep writes all NUM_BLOCKS link entries, one a cycle, in_ready
// low. Free: result valid the cycle after accept, one per cycle while the
// result is taken. Allocate: waits in S_READ for the registered link memory
// read at the list head, taking no new item there; empty gives ST_EMPTY.
// Depends on flba_pkg, flba_ctrl, flba_datapath.
module free_list_block_allocator #(
    parameter int NUM_BLOCKS = flba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [flba_pkg::IDX_W-1:0]    block_index,
    input  logic                          block_valid,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [flba_pkg::STATUS_W-1:0] status,
    output logic [flba_pkg::IDX_W-1:0]    granted_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [flba_pkg::CFG_W-1:0]    block_count
);

    flba_pkg::flba_cmd_t  cmd;
    flba_pkg::flba_stat_t stat;

    // Sequencer
    flba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_kind   (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Link memory and list state
    flba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_data       (block_count),
        .in_kind        (kind),
        .in_index       (block_index),
        .in_block_valid (block_valid),
        .out_status     (status),
        .out_granted    (granted_index)
    );

endmodule

FILE: rtl/flba_datapath.sv
// flba_datapath: link memory, list head, block count register, relink
// sweep pointer and result register. Depends on flba_pkg.
module flba_datapath #(
    parameter int NUM_BLOCKS = flba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  flba_pkg::flba_cmd_t           cmd,
    output flba_pkg::flba_stat_t          stat,
    input  logic [flba_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_kind,
    input  logic [flba_pkg::IDX_W-1:0]    in_index,
    input  logic                          in_block_valid,
    output logic [flba_pkg::STATUS_W-1:0] out_status,
    output logic [flba_pkg::IDX_W-1:0]    out_granted
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam logic [LW-1:0] LNULL = LW'(NUM_BLOCKS);
    localparam int COUNT_RST = (flba_pkg::COUNT_RESET > NUM_BLOCKS) ?
                               NUM_BLOCKS : flba_pkg::COUNT_RESET;

    logic [flba_pkg::CFG_W-1:0] count_reg, count_next;
    logic [LW-1:0]              head_reg, head_next;
    logic [AW-1:0]              sweep_idx_reg, sweep_idx_next;

    logic [LW-1:0]              link_mem [NUM_BLOCKS];
    logic [LW-1:0]              rd_data_reg;

    flba_pkg::status_t          out_status_reg, out_status_next;
    logic [flba_pkg::IDX_W-1:0] out_granted_reg, out_granted_next;
    logic                       out_load;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [LW-1:0]              wr_data;

    logic                       head_null;
    logic                       free_ok;
    logic [flba_pkg::CFG_W-1:0] cfg_sat;
    logic [LW-1:0]              sweep_link;

    assign head_null       = (head_reg == LNULL);
    assign stat.head_null  = head_null;
    assign stat.sweep_last = (sweep_idx_reg == AW'(NUM_BLOCKS - 1));

    // Block count write: zero becomes one, saturate at pool size
    always_comb
    begin
        if (cfg_data == '0)
            cfg_sat = flba_pkg::CFG_W'(1);
        else if (32'(cfg_data) > NUM_BLOCKS)
            cfg_sat = flba_pkg::CFG_W'(NUM_BLOCKS);
        else
            cfg_sat = cfg_data;
    end

    // Relink value for the entry under the sweep pointer
    assign sweep_link = ((32'(sweep_idx_reg) + 32'd1) < 32'(count_reg)) ?
                        LW'(sweep_idx_reg + 1'b1) : LNULL;

    // Free is honored only for a real block below the count
    assign free_ok = in_block_valid &&
                     (flba_pkg::CFG_W'(in_index) < count_reg);

    // Next-state and memory write selection
    always_comb
    begin
        count_next       = count_reg;
        head_next        = head_reg;
        sweep_idx_next   = sweep_idx_reg;
        out_load         = 1'b0;
        out_status_next  = flba_pkg::ST_OK;
        out_granted_next = '0;
        wr_en            = 1'b0;
        wr_addr          = sweep_idx_reg;
        wr_data          = sweep_link;

        if (cmd.cfg_load)
        begin
            count_next     = cfg_sat;
            sweep_idx_next = '0;
            head_next      = '0;
        end
        else if (cmd.sweep_step)
        begin
            wr_en          = 1'b1;
            sweep_idx_next = sweep_idx_reg + 1'b1;
        end
        else if (cmd.accept)
        begin
            if (in_kind == flba_pkg::KIND_FREE)
            begin
                out_load = 1'b1;
                if (free_ok)
                begin
                    // push: new block links to old head
                    wr_en     = 1'b1;
                    wr_addr   = AW'(in_index);
                    wr_data   = head_reg;
                    head_next = LW'(in_index);
                end
                else
                begin
                    out_status_next = flba_pkg::ST_IGNORED;
                end
            end
            else if (head_null)
            begin
                out_load        = 1'b1;
                out_status_next = flba_pkg::ST_EMPTY;
            end
        end
        else if (cmd.finish)
        begin
            // pop: link read at the head becomes the new head
            out_load         = 1'b1;
            out_granted_next = flba_pkg::IDX_W'(head_reg);
            head_next        = rd_data_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= flba_pkg::CFG_W'(COUNT_RST);
            head_reg      <= '0;
            sweep_idx_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            sweep_idx_reg <= sweep_idx_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg  <= out_status_next;
            out_granted_reg <= out_granted_next;
        end
    end

    // Link memory: one write port, registered read at the head
    always_ff @(posedge clk)
    begin
        if (wr_en)
            link_mem[wr_addr] <= wr_data;
        rd_data_reg <= link_mem[head_reg[AW-1:0]];
    end

    assign out_status  = out_status_reg;
    assign out_granted = out_granted_reg;

`ifndef ASSERT_OFF
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg == LNULL || head_reg < LNULL)
        else $error("list head outside pool");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && 32'(count_reg) <= NUM_BLOCKS)
        else $error("block count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !head_null)
        else $error("pop completed on empty list");
`endif

endmodule

FILE: rtl/flba_ctrl.sv
// flba_ctrl: sequencing FSM for relink sweep, item acceptance and result
// handshake. Depends on flba_pkg.
module flba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_kind,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    output flba_pkg::flba_cmd_t  cmd,
    input  flba_pkg::flba_stat_t stat
);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // Take an item only when idle, no cfg_valid, slot free or draining
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready) &&
                       !cfg_valid;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // Commands to the datapath
    always_comb
    begin
        cmd.cfg_load   = cfg_valid;
        cmd.sweep_step = (state_reg == S_SWEEP) && !cfg_valid;
        cmd.accept     = accept;
        cmd.finish     = (state_reg == S_READ) && !cfg_valid;
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_valid)
        begin
            state_next = S_SWEEP;
        end
        else
        begin
            case (state_reg)
                S_SWEEP:
                begin
                    if (stat.sweep_last)
                        state_next = S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_kind == flba_pkg::KIND_ALLOC && !stat.head_null)
                            state_next = S_READ;
                        else
                            out_valid_next = 1'b1;
                    end
                end
                S_READ:
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                default:
                begin
                    state_next = S_SWEEP;
                end
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_pop_waits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_kind == flba_pkg::KIND_ALLOC && !stat.head_null |=>
        state_reg == S_READ && !out_valid_reg)
        else $error("pop did not wait for link read");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ && !cfg_valid |=> out_valid_reg && state_reg == S_IDLE)
        else $error("pop result not presented");

    a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> state_reg == S_SWEEP)
        else $error("count write did not start relink");
`endif

endmodule
